### hw/rtl/lcdfb_pkg.sv
package lcdfb_pkg;

	// Input command codes
	localparam logic [2:0] CMD_DRAW    = 3'd0;
	localparam logic [2:0] CMD_FILL    = 3'd1;
	localparam logic [2:0] CMD_INIT    = 3'd2;
	localparam logic [2:0] CMD_REFRESH = 3'd3;
	localparam logic [2:0] CMD_TICK    = 3'd4;

	// Armed sequence kinds
	localparam logic [1:0] KIND_IDLE    = 2'd0;
	localparam logic [1:0] KIND_INIT    = 2'd1;
	localparam logic [1:0] KIND_REFRESH = 2'd2;

	// Configuration register indexes
	localparam logic [2:0] REG_INVERT   = 3'd0;
	localparam logic [2:0] REG_SEGREV   = 3'd1;
	localparam logic [2:0] REG_COMREV   = 3'd2;
	localparam logic [2:0] REG_BIAS     = 3'd3;
	localparam logic [2:0] REG_RATIO    = 3'd4;
	localparam logic [2:0] REG_CONTRAST = 3'd5;
	localparam logic [2:0] REG_BOOSTER  = 3'd6;

	localparam logic [5:0] CONTRAST_RESET = 6'd32;

	// LCD controller command bytes
	localparam logic [7:0] LCD_DISP_OFF   = 8'hAE;
	localparam logic [7:0] LCD_DISP_ON    = 8'hAF;
	localparam logic [7:0] LCD_START_LINE = 8'h40;
	localparam logic [7:0] LCD_PAGE_ADDR  = 8'hB0;
	localparam logic [7:0] LCD_COL_HIGH   = 8'h10;
	localparam logic [7:0] LCD_COL_LOW    = 8'h00;
	localparam logic [7:0] LCD_SEG_DIR    = 8'hA0;
	localparam logic [7:0] LCD_DISP_MODE  = 8'hA6;
	localparam logic [7:0] LCD_BIAS       = 8'hA2;
	localparam logic [7:0] LCD_VOLUME     = 8'h81;
	localparam logic [7:0] LCD_BOOSTER    = 8'hF8;
	localparam logic [7:0] LCD_POWER_ALL  = 8'h2F;
	localparam logic [7:0] LCD_RATIO      = 8'h20;
	localparam logic [7:0] LCD_COM_DIR    = 8'hC0;

	localparam logic [3:0] INIT_LAST_STEP = 4'd12;

	// Sequencer steps
	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_DRAW_RD  = 3'd1;
	localparam logic [2:0] ST_DRAW_WR  = 3'd2;
	localparam logic [2:0] ST_FILL     = 3'd3;
	localparam logic [2:0] ST_TICK_RD  = 3'd4;
	localparam logic [2:0] ST_TICK_OUT = 3'd5;

	// Jump kinds
	localparam logic [1:0] J_GOTO     = 2'd0;
	localparam logic [1:0] J_DISPATCH = 2'd1;
	localparam logic [1:0] J_LOOP     = 2'd2;

	typedef struct packed {
		logic       busy;
		logic       mem_rd;
		logic       mem_we;
		logic       wr_merge;
		logic       emit;
		logic [1:0] jump;
		logic [2:0] target;
	} ctrl_t;

	typedef struct packed {
		logic       invert_mode;
		logic       segment_reverse;
		logic [3:0] com_reverse;
		logic       bias_select;
		logic [2:0] regulation_ratio;
		logic [5:0] contrast_level;
		logic [1:0] booster_level;
	} cfg_t;

	// Microcode table: one control word per sequencer step.
	function automatic ctrl_t ucode(input logic [2:0] step);
		ctrl_t c;
		c = '{busy: 1'b0, mem_rd: 1'b0, mem_we: 1'b0, wr_merge: 1'b0, emit: 1'b0,
			jump: J_GOTO, target: ST_IDLE};
		case (step)
			ST_IDLE: begin
				c.jump = J_DISPATCH;
			end
			ST_DRAW_RD: begin
				c.busy = 1'b1;
				c.mem_rd = 1'b1;
				c.target = ST_DRAW_WR;
			end
			ST_DRAW_WR: begin
				c.busy = 1'b1;
				c.mem_we = 1'b1;
				c.wr_merge = 1'b1;
			end
			ST_FILL: begin
				c.busy = 1'b1;
				c.mem_we = 1'b1;
				c.jump = J_LOOP;
			end
			ST_TICK_RD: begin
				c.busy = 1'b1;
				c.mem_rd = 1'b1;
				c.target = ST_TICK_OUT;
			end
			ST_TICK_OUT: begin
				c.busy = 1'b1;
				c.emit = 1'b1;
			end
			default: begin
				c.busy = 1'b1;
			end
		endcase
		return c;
	endfunction

	function automatic logic [7:0] init_byte(input logic [3:0] step, input cfg_t cfg);
		logic [7:0] b;
		case (step)
			4'd0:    b = LCD_DISP_OFF;
			4'd1:    b = LCD_DISP_MODE | {7'd0, cfg.invert_mode};
			4'd2:    b = LCD_SEG_DIR | {7'd0, cfg.segment_reverse};
			4'd3:    b = LCD_COM_DIR | {4'd0, cfg.com_reverse};
			4'd4:    b = LCD_START_LINE;
			4'd5:    b = LCD_BIAS | {7'd0, cfg.bias_select};
			4'd6:    b = LCD_RATIO | {5'd0, cfg.regulation_ratio};
			4'd7:    b = LCD_VOLUME;
			4'd8:    b = {2'd0, cfg.contrast_level};
			4'd9:    b = LCD_BOOSTER;
			4'd10:   b = {6'd0, cfg.booster_level};
			4'd11:   b = LCD_POWER_ALL;
			default: b = LCD_DISP_ON;
		endcase
		return b;
	endfunction

endpackage

### hw/rtl/lcd_page_framebuffer_controller_unit.sv
// Page-organized monochrome framebuffer with a byte sequencer for a page-mode LCD.
// Commands enter on start/cmd/pos_x/pos_y/pixel_on and are taken when start is high
// and busy is low. Draw reads, modifies and writes back one store byte.
// Fill writes every byte, one per cycle.
// Start init and start refresh only arm a sequence.
// A tick while a sequence is armed passes through dispatch, store read and emit; the
// emitted byte appears on out_byte/is_data/seq_last with valid high for exactly one
// cycle, registered from the emit step.
// Results cannot be held off: the receiver must take each byte in its valid cycle.
// Configuration goes through the APB port; register i lies at byte address 4*i.
// At reset the control state clears and the sequencer sweeps the store to zero,
// one byte per cycle with busy high; APB writes are taken during that sweep.
module lcd_page_framebuffer_controller_unit
	import lcdfb_pkg::*;
#(
	parameter int WIDTH  = 128,
	parameter int HEIGHT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  cmd,
	input  logic [7:0]  pos_x,
	input  logic [6:0]  pos_y,
	input  logic        pixel_on,
	output logic        valid,
	output logic [7:0]  out_byte,
	output logic        is_data,
	output logic        seq_last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int NPAGES    = (HEIGHT + 7) / 8;
	localparam int STORE_LEN = WIDTH * NPAGES;
	localparam int AW        = $clog2(STORE_LEN);

	localparam logic [8:0]    WIDTH_X   = 9'(WIDTH);
	localparam logic [6:0]    HEIGHT_Y  = 7'(HEIGHT);
	localparam logic [AW-1:0] WIDTH_A   = AW'(WIDTH);
	localparam logic [AW-1:0] LAST_A    = AW'(STORE_LEN - 1);
	localparam logic [7:0]    BYTE_LAST = 8'(WIDTH + 2);
	localparam logic [2:0]    PAGE_LAST = 3'(NPAGES - 1);

	logic [7:0] mem [STORE_LEN];

	logic [2:0]    step_q;
	logic [AW-1:0] addr_q;
	logic [7:0]    rdata_q;
	logic [7:0]    fill_val_q;
	logic [7:0]    bit_q;
	logic          on_q;
	logic [1:0]    seq_kind_q;
	logic [2:0]    page_q;
	logic [7:0]    byte_q;
	logic [3:0]    init_step_q;
	cfg_t          cfg_q;
	logic          valid_q;
	logic [7:0]    out_byte_q;
	logic          is_data_q;
	logic          seq_last_q;

	ctrl_t         ctrl;
	logic          accept;
	logic          pending;
	logic          draw_ok;
	logic [2:0]    step_d;
	logic [AW-1:0] draw_addr;
	logic [AW-1:0] refresh_addr;
	logic [7:0]    wdata;
	logic [7:0]    emit_byte;
	logic          emit_data;
	logic          emit_last;
	logic          cfg_wr;

	assign ctrl    = ucode(step_q);
	assign busy    = ctrl.busy;
	assign accept  = start && !ctrl.busy;
	assign pending = seq_kind_q != KIND_IDLE;
	assign draw_ok = !pending && ({1'b0, pos_x} < WIDTH_X) && (pos_y < HEIGHT_Y);

	assign draw_addr    = AW'(pos_x) + AW'(pos_y[5:3]) * WIDTH_A;
	assign refresh_addr = AW'(page_q) * WIDTH_A + AW'(byte_q - 8'd3);

	assign wdata = !ctrl.wr_merge ? fill_val_q :
		(on_q ? (rdata_q | bit_q) : (rdata_q & ~bit_q));

	// Next step: plain goto, command dispatch from idle, or the fill loop.
	always_comb begin
		step_d = ctrl.target;
		case (ctrl.jump)
			J_DISPATCH: begin
				step_d = ST_IDLE;
				if (accept) begin
					case (cmd)
						CMD_DRAW: if (draw_ok) step_d = ST_DRAW_RD;
						CMD_FILL: if (!pending) step_d = ST_FILL;
						CMD_TICK: if (pending) step_d = ST_TICK_RD;
						default: step_d = ST_IDLE;
					endcase
				end
			end
			J_LOOP: begin
				step_d = (addr_q == LAST_A) ? ctrl.target : step_q;
			end
			default: begin
				step_d = ctrl.target;
			end
		endcase
	end

	// Byte produced by a tick, from the armed sequence and its counters.
	always_comb begin
		emit_byte = rdata_q;
		emit_data = 1'b0;
		emit_last = 1'b0;
		if (seq_kind_q == KIND_INIT) begin
			emit_byte = init_byte(init_step_q, cfg_q);
			emit_last = init_step_q >= INIT_LAST_STEP;
		end else begin
			case (byte_q)
				8'd0: emit_byte = LCD_PAGE_ADDR | {5'd0, page_q};
				8'd1: emit_byte = LCD_COL_HIGH;
				8'd2: emit_byte = LCD_COL_LOW;
				default: begin
					emit_byte = rdata_q;
					emit_data = 1'b1;
					emit_last = (byte_q == BYTE_LAST) && (page_q >= PAGE_LAST);
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.mem_we) begin
			mem[addr_q] <= wdata;
		end
		if (ctrl.mem_rd) begin
			rdata_q <= mem[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= ST_FILL;
			addr_q      <= '0;
			fill_val_q  <= 8'h00;
			bit_q       <= 8'h00;
			on_q        <= 1'b0;
			seq_kind_q  <= KIND_IDLE;
			page_q      <= 3'd0;
			byte_q      <= 8'd0;
			init_step_q <= 4'd0;
			valid_q     <= 1'b0;
			out_byte_q  <= 8'h00;
			is_data_q   <= 1'b0;
			seq_last_q  <= 1'b0;
		end else begin
			step_q  <= step_d;
			valid_q <= ctrl.emit;
			if (accept) begin
				case (cmd)
					CMD_DRAW: begin
						addr_q <= draw_addr;
						bit_q  <= 8'd1 << pos_y[2:0];
						on_q   <= pixel_on;
					end
					CMD_FILL: begin
						addr_q     <= '0;
						fill_val_q <= {8{pixel_on}};
					end
					CMD_INIT, CMD_REFRESH: begin
						if (!pending) begin
							seq_kind_q  <= (cmd == CMD_INIT) ? KIND_INIT : KIND_REFRESH;
							init_step_q <= 4'd0;
							page_q      <= 3'd0;
							byte_q      <= 8'd0;
						end
					end
					CMD_TICK: begin
						addr_q <= refresh_addr;
					end
					default: begin
					end
				endcase
			end
			if (ctrl.jump == J_LOOP && addr_q != LAST_A) begin
				addr_q <= addr_q + 1'b1;
			end
			if (ctrl.emit) begin
				out_byte_q <= emit_byte;
				is_data_q  <= emit_data;
				seq_last_q <= emit_last;
				if (seq_kind_q == KIND_INIT) begin
					if (emit_last) begin
						seq_kind_q  <= KIND_IDLE;
						init_step_q <= 4'd0;
					end else begin
						init_step_q <= init_step_q + 4'd1;
					end
				end else if (byte_q >= BYTE_LAST) begin
					byte_q <= 8'd0;
					if (emit_last) begin
						seq_kind_q <= KIND_IDLE;
						page_q     <= 3'd0;
					end else begin
						page_q <= page_q + 3'd1;
					end
				end else begin
					byte_q <= byte_q + 8'd1;
				end
			end
		end
	end

	assign valid    = valid_q;
	assign out_byte = out_byte_q;
	assign is_data  = is_data_q;
	assign seq_last = seq_last_q;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{invert_mode: 1'b0, segment_reverse: 1'b0, com_reverse: 4'd0,
				bias_select: 1'b0, regulation_ratio: 3'd0,
				contrast_level: CONTRAST_RESET, booster_level: 2'd0};
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_INVERT:   cfg_q.invert_mode      <= pwdata[0];
				REG_SEGREV:   cfg_q.segment_reverse  <= pwdata[0];
				REG_COMREV:   cfg_q.com_reverse      <= pwdata[3:0];
				REG_BIAS:     cfg_q.bias_select      <= pwdata[0];
				REG_RATIO:    cfg_q.regulation_ratio <= pwdata[2:0];
				REG_CONTRAST: cfg_q.contrast_level   <= pwdata[5:0];
				REG_BOOSTER:  cfg_q.booster_level    <= pwdata[1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_INVERT:   prdata = {31'd0, cfg_q.invert_mode};
			REG_SEGREV:   prdata = {31'd0, cfg_q.segment_reverse};
			REG_COMREV:   prdata = {28'd0, cfg_q.com_reverse};
			REG_BIAS:     prdata = {31'd0, cfg_q.bias_select};
			REG_RATIO:    prdata = {29'd0, cfg_q.regulation_ratio};
			REG_CONTRAST: prdata = {26'd0, cfg_q.contrast_level};
			REG_BOOSTER:  prdata = {30'd0, cfg_q.booster_level};
			default:      prdata = 32'd0;
		endcase
	end

	// A result only follows the emit step of the microcode.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(step_q == ST_TICK_OUT))
		else $error("result strobe without an emit step");

	// The store is never written while a sequence is armed.
	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.mem_we |-> seq_kind_q == KIND_IDLE)
		else $error("store written while a sequence is pending");

	// The final byte of a sequence leaves the sequencer disarmed.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid && seq_last |-> seq_kind_q == KIND_IDLE)
		else $error("sequence still armed after its last byte");

	// Data bytes only come from a refresh.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid && is_data |-> $past(seq_kind_q == KIND_REFRESH))
		else $error("data byte outside a refresh sequence");

endmodule

### dv/lcd_page_framebuffer_controller_unit_tb.sv
module lcd_page_framebuffer_controller_unit_tb;
	import lcdfb_pkg::*;

	localparam int WIDTH  = 128;
	localparam int HEIGHT = 64;
	localparam int NPAGES = (HEIGHT + 7) / 8;
	localparam int STORE_DEPTH = WIDTH * NPAGES;
	localparam int RANDOM_PER_PHASE = 40;
	localparam int SETTLE_CYCLES = 8;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int MAX_REPORTS = 100;

	// Command codes the block does not define.
	localparam logic [2:0] CMD_SPARE_LO = 3'd5;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_data;
		logic       seq_last;
	} lcd_byte_t;

	localparam lcd_byte_t NO_BYTE = '0;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] x;
		logic [6:0] y;
		logic       on;
		int         reps;
		bit         typed;
		bit         typed_has;
		lcd_byte_t  typed_byte;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  cmd;
	logic [7:0]  pos_x;
	logic [6:0]  pos_y;
	logic        pixel_on;
	logic        valid;
	logic [7:0]  out_byte;
	logic        is_data;
	logic        seq_last;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// Typed expectation that rides along with a directed transaction.
	logic        row_typed;
	logic        row_typed_has;
	lcd_byte_t   row_typed_byte;

	// Mirror of the block's state, advanced at every accepted transaction.
	logic [7:0]  frame_mirror [STORE_DEPTH];
	logic [1:0]  mirror_kind;
	int          mirror_page;
	int          mirror_col;
	logic [3:0]  mirror_step;
	cfg_t        mirror_cfg;

	lcd_byte_t   lcd_expect_q [$];
	int          mismatches;
	int          quiet_cycles;
	bit          quiet_stretch;
	dir_row_t    dir_rows [23];

	lcd_page_framebuffer_controller_unit #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) u_top (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic flag_mismatch(input string what);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("MISMATCH at %0t: %s", $time, what);
	endtask

	task automatic predict_lcd_byte(input logic [2:0] op, input logic [7:0] x,
			input logic [6:0] y, input logic on, output bit has, output lcd_byte_t b);
		int idx;
		bit last_one;
		bit idle;
		has = 1'b0;
		b = NO_BYTE;
		idle = (mirror_kind == KIND_IDLE);
		case (op)
			CMD_DRAW: begin
				if (idle && int'(x) < WIDTH && int'(y) < HEIGHT) begin
					idx = int'(x) + (int'(y) / 8) * WIDTH;
					frame_mirror[idx][y[2:0]] = on;
				end
			end
			CMD_FILL: begin
				if (idle)
					foreach (frame_mirror[i])
						frame_mirror[i] = {8{on}};
			end
			CMD_INIT, CMD_REFRESH: begin
				if (idle) begin
					mirror_kind = (op == CMD_INIT) ? KIND_INIT : KIND_REFRESH;
					mirror_step = '0;
					mirror_page = 0;
					mirror_col = 0;
				end
			end
			CMD_TICK: begin
				if (mirror_kind == KIND_INIT) begin
					has = 1'b1;
					case (mirror_step)
						4'd0:    b.out_byte = LCD_DISP_OFF;
						4'd1:    b.out_byte = LCD_DISP_MODE | 8'(mirror_cfg.invert_mode);
						4'd2:    b.out_byte = LCD_SEG_DIR | 8'(mirror_cfg.segment_reverse);
						4'd3:    b.out_byte = LCD_COM_DIR | 8'(mirror_cfg.com_reverse);
						4'd4:    b.out_byte = LCD_START_LINE;
						4'd5:    b.out_byte = LCD_BIAS | 8'(mirror_cfg.bias_select);
						4'd6:    b.out_byte = LCD_RATIO | 8'(mirror_cfg.regulation_ratio);
						4'd7:    b.out_byte = LCD_VOLUME;
						4'd8:    b.out_byte = 8'(mirror_cfg.contrast_level);
						4'd9:    b.out_byte = LCD_BOOSTER;
						4'd10:   b.out_byte = 8'(mirror_cfg.booster_level);
						4'd11:   b.out_byte = LCD_POWER_ALL;
						default: b.out_byte = LCD_DISP_ON;
					endcase
					b.is_data = 1'b0;
					b.seq_last = (mirror_step >= INIT_LAST_STEP);
					if (b.seq_last) begin
						mirror_kind = KIND_IDLE;
						mirror_step = '0;
					end else begin
						mirror_step = mirror_step + 4'd1;
					end
				end else if (mirror_kind == KIND_REFRESH) begin
					has = 1'b1;
					last_one = 1'b0;
					// Every page opens with three address commands, then the columns.
					if (mirror_col == 0) begin
						b.out_byte = LCD_PAGE_ADDR | 8'(mirror_page);
					end else if (mirror_col == 1) begin
						b.out_byte = LCD_COL_HIGH;
					end else if (mirror_col == 2) begin
						b.out_byte = LCD_COL_LOW;
					end else begin
						b.out_byte = frame_mirror[mirror_page * WIDTH + mirror_col - 3];
						b.is_data = 1'b1;
						last_one = (mirror_col - 3 == WIDTH - 1) && (mirror_page >= NPAGES - 1);
					end
					b.seq_last = last_one;
					if (mirror_col >= WIDTH + 2) begin
						mirror_col = 0;
						if (last_one) begin
							mirror_kind = KIND_IDLE;
							mirror_page = 0;
						end else begin
							mirror_page++;
						end
					end else begin
						mirror_col++;
					end
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk) begin : check_and_predict
		lcd_byte_t want;
		lcd_byte_t pred;
		bit pred_has;
		if (arst_n) begin
			if (valid) begin
				if (lcd_expect_q.size() == 0) begin
					flag_mismatch($sformatf("byte %02h emitted with nothing expected", out_byte));
				end else begin
					want = lcd_expect_q.pop_front();
					if (out_byte !== want.out_byte)
						flag_mismatch($sformatf("out_byte %02h, expected %02h",
							out_byte, want.out_byte));
					if (is_data !== want.is_data)
						flag_mismatch($sformatf("is_data %b, expected %b on byte %02h",
							is_data, want.is_data, want.out_byte));
					if (seq_last !== want.seq_last)
						flag_mismatch($sformatf("seq_last %b, expected %b on byte %02h",
							seq_last, want.seq_last, want.out_byte));
				end
			end
			if (start && !busy) begin
				predict_lcd_byte(cmd, pos_x, pos_y, pixel_on, pred_has, pred);
				if (row_typed) begin
					pred_has = row_typed_has;
					pred = row_typed_byte;
				end
				if (pred_has)
					lcd_expect_q.push_back(pred);
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_INVERT:   mirror_cfg.invert_mode = pwdata[0];
					REG_SEGREV:   mirror_cfg.segment_reverse = pwdata[0];
					REG_COMREV:   mirror_cfg.com_reverse = pwdata[3:0];
					REG_BIAS:     mirror_cfg.bias_select = pwdata[0];
					REG_RATIO:    mirror_cfg.regulation_ratio = pwdata[2:0];
					REG_CONTRAST: mirror_cfg.contrast_level = pwdata[5:0];
					REG_BOOSTER:  mirror_cfg.booster_level = pwdata[1:0];
					default: ;
				endcase
			end
			if (valid || (start && !busy)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("lcd_page_framebuffer_controller_unit verification failed");
					$finish;
				end
			end
		end
	end

	// Called at a falling edge; returns at a falling edge once the transaction is taken
	// and any gap that follows it has passed.
	task automatic send_item(input logic [2:0] op, input logic [7:0] x, input logic [6:0] y,
			input logic on, input bit typed, input bit typed_has, input lcd_byte_t typed_byte);
		int gap;
		int r;
		start <= 1'b1;
		cmd <= op;
		pos_x <= x;
		pos_y <= y;
		pixel_on <= on;
		row_typed <= typed;
		row_typed_has <= typed_has;
		row_typed_byte <= typed_byte;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
		r = $urandom_range(0, 99);
		if (quiet_stretch || r < 55)
			gap = 0;
		else if (r < 90)
			gap = $urandom_range(1, 3);
		else if (r < 98)
			gap = $urandom_range(4, 12);
		else
			gap = $urandom_range(20, 60);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap)
				@(negedge clk);
		end
	endtask

	task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Waits until every expected byte is out and the last command, a fill included, is done.
	task automatic settle();
		start <= 1'b0;
		while (lcd_expect_q.size() != 0 || busy)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	initial begin : stimulus
		cfg_t        next_cfg;
		logic [31:0] rbits;
		logic [2:0]  op;
		logic [7:0]  px;
		logic [6:0]  py;
		logic        pon;
		int          r;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_DRAW;
		pos_x = '0;
		pos_y = '0;
		pixel_on = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		row_typed = 1'b0;
		row_typed_has = 1'b0;
		row_typed_byte = NO_BYTE;
		foreach (frame_mirror[i])
			frame_mirror[i] = '0;
		mirror_kind = KIND_IDLE;
		mirror_page = 0;
		mirror_col = 0;
		mirror_step = '0;
		mirror_cfg = '0;
		mirror_cfg.contrast_level = CONTRAST_RESET;
		mismatches = 0;
		quiet_cycles = 0;
		quiet_stretch = 1'b0;

		dir_rows = '{
			'{CMD_TICK, 8'd0, 7'd0, 1'b0, 1, 1'b1, 1'b0, NO_BYTE},
			'{CMD_SPARE_HI, 8'd255, 7'd127, 1'b1, 1, 1'b1, 1'b0, NO_BYTE},
			'{CMD_FILL, 8'd0, 7'd0, 1'b1, 1, 1'b0, 1'b0, NO_BYTE},
			'{CMD_INIT, 8'd0, 7'd0, 1'b0, 1, 1'b0, 1'b0, NO_BYTE},
			'{CMD_TICK, 8'd0, 7'd0, 1'b0, 1, 1'b1, 1'b1, '{LCD_DISP_OFF, 1'b0, 1'b0}},
			'{CMD_TICK, 8'd0, 7'd0, 1'b0, 1, 1'b1, 1'b1, '{LCD_DISP_MODE, 1'b0, 1'b0}},
			// Draw, fill and a second start are all dropped while init is pending.
			'{CMD_DRAW, 8'd0, 7'd0, 1'b0, 1, 1'b0, 1'b0, NO_BYTE},
			'{CMD_FILL, 8'd0, 7'd0, 1'b0, 1, 1'b0, 1'b0, NO_BYTE},
			'{CMD_REFRESH, 8'd0, 7'd0, 1'b0, 1, 1'b0, 1'b0, NO_BYTE},
			'{CMD_TICK, 8'd0, 7'd0, 1'b0, 6, 1'b0, 1'b0, NO_BYTE},
			'{CMD_TICK, 8'd0, 7'd0, 1'b0, 1, 1'b1, 1'b1, '{{2'b00, CONTRAST_RESET}, 1'b0, 1'b0}},
			'{CMD_TICK, 8'd0, 7'd0, 1'b0, 3, 1'b0, 1'b0, NO_BYTE},
			'{CMD_TICK, 8'd0, 7'd0, 1'b0, 1, 1'b1, 1'b1, '{LCD_DISP_ON, 1'b0, 1'b1}},
			'{CMD_TICK, 8'd0, 7'd0, 1'b0, 1, 1'b1, 1'b0, NO_BYTE},
			'{CMD_DRAW, 8'd3, 7'd3, 1'b0, 1, 1'b0, 1'b0, NO_BYTE},
			'{CMD_DRAW, 8'd3, 7'd3, 1'b1, 1, 1'b0, 1'b0, NO_BYTE},
			'{CMD_DRAW, 8'd127, 7'd63, 1'b0, 1, 1'b0, 1'b0, NO_BYTE},
			'{CMD_DRAW, 8'd128, 7'd0, 1'b0, 1, 1'b0, 1'b0, NO_BYTE},
			'{CMD_DRAW, 8'd0, 7'd64, 1'b0, 1, 1'b0, 1'b0, NO_BYTE},
			'{CMD_DRAW, 8'd255, 7'd127, 1'b0, 1, 1'b0, 1'b0, NO_BYTE},
			'{CMD_REFRESH, 8'd0, 7'd0, 1'b0, 1, 1'b0, 1'b0, NO_BYTE},
			'{CMD_TICK, 8'd0, 7'd0, 1'b0, 1, 1'b1, 1'b1, '{LCD_PAGE_ADDR, 1'b0, 1'b0}},
			'{CMD_TICK, 8'd0, 7'd0, 1'b0, 1047, 1'b0, 1'b0, NO_BYTE}
		};

		repeat (3)
			@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			repeat (dir_rows[i].reps)
				send_item(dir_rows[i].op, dir_rows[i].x, dir_rows[i].y, dir_rows[i].on,
					dir_rows[i].typed, dir_rows[i].typed_has, dir_rows[i].typed_byte);
		settle();

		for (int ph = 0; ph < 4; ph++) begin
			if (ph == 0) begin
				next_cfg = '{1'b1, 1'b1, 4'hF, 1'b1, 3'h7, 6'h3F, 2'h3};
			end else if (ph == 1) begin
				next_cfg = '0;
			end else begin
				rbits = $urandom;
				next_cfg = rbits[$bits(cfg_t)-1:0];
			end
			cfg_write(REG_INVERT, 32'(next_cfg.invert_mode));
			cfg_write(REG_SEGREV, 32'(next_cfg.segment_reverse));
			cfg_write(REG_COMREV, 32'(next_cfg.com_reverse));
			cfg_write(REG_BIAS, 32'(next_cfg.bias_select));
			cfg_write(REG_RATIO, 32'(next_cfg.regulation_ratio));
			cfg_write(REG_CONTRAST, 32'(next_cfg.contrast_level));
			cfg_write(REG_BOOSTER, 32'(next_cfg.booster_level));
			psel <= 1'b0;
			penable <= 1'b0;
			pwrite <= 1'b0;

			// Each setting is seen at least once through a full init sequence.
			send_item(CMD_INIT, 8'($urandom), 7'($urandom), 1'($urandom), 1'b0, 1'b0, NO_BYTE);
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				if (n % 10 == 0)
					quiet_stretch = ($urandom_range(0, 3) == 0);
				r = $urandom_range(0, 99);
				px = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, WIDTH - 1));
				py = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, HEIGHT - 1));
				pon = 1'($urandom);
				if (mirror_kind == KIND_IDLE) begin
					if (r < 70)
						op = CMD_DRAW;
					else if (r < 72)
						op = CMD_FILL;
					else if (r < 81)
						op = CMD_INIT;
					else if (r < 94)
						op = CMD_TICK;
					else
						op = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
				end else begin
					// Mostly keep the armed sequence moving, with some ignored noise.
					if (r < 85)
						op = CMD_TICK;
					else if (r < 90)
						op = CMD_DRAW;
					else if (r < 92)
						op = CMD_FILL;
					else if (r < 94)
						op = CMD_INIT;
					else if (r < 96)
						op = CMD_REFRESH;
					else
						op = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
				end
				send_item(op, px, py, pon, 1'b0, 1'b0, NO_BYTE);
			end
			quiet_stretch = 1'b0;
			while (mirror_kind != KIND_IDLE)
				send_item(CMD_TICK, 8'($urandom), 7'($urandom), 1'($urandom), 1'b0, 1'b0, NO_BYTE);
			settle();
		end

		if (mismatches == 0)
			$display("lcd_page_framebuffer_controller_unit verification clean");
		else
			$display("lcd_page_framebuffer_controller_unit verification failed");
		$finish;
	end

endmodule
